// ===== hw/rtl/falg_pkg.sv =====
// ============================================================================
// falg_pkg: shared definitions for the failed-attempt lockout gate
// Widths, opcodes, register indexes and the constants used for the
// nanosecond to millisecond conversion.
// ============================================================================
`default_nettype none

package falg_pkg;

  // Stream word layout.
  localparam int unsigned IN_DATA_W  = 64;  // now_ns
  localparam int unsigned IN_USER_W  = 2;   // opcode
  localparam int unsigned OUT_DATA_W = 40;  // retry_after_ms, zero filled
  localparam int unsigned OUT_USER_W = 1;   // gate_status

  // Field and state widths.
  localparam int unsigned NOW_W   = 64;
  localparam int unsigned RETRY_W = 33;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned FREE_W  = 8;
  localparam int unsigned NSPM_W  = 20;
  localparam int unsigned NS_W    = MS_W + NSPM_W;

  // One millisecond in nanoseconds, and the saturated failure count.
  localparam logic [NSPM_W-1:0]  NS_PER_MS = 20'd1000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Largest doubling shift before the lockout is simply the cap.
  localparam logic [COUNT_W-1:0] SHIFT_LIMIT = 32'd33;

  // Division by one million: drop six bits (divide by 64), then multiply by
  // the reciprocal of 15625. The reciprocal is exact for 46-bit dividends.
  localparam int unsigned DIV_SHIFT = 6;
  localparam int unsigned DIV_X_W   = NS_W - DIV_SHIFT;
  localparam int unsigned RECIP_K   = 60;
  localparam int unsigned RECIP_W   = 47;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_K) + 64'd15624) / 64'd15625);
  localparam int unsigned SPLIT = 23;
  localparam int unsigned PP_W  = RECIP_W;
  localparam int unsigned MID_W = PP_W + 1;
  localparam int unsigned TOT_W = DIV_X_W + RECIP_W;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [FREE_W-1:0] FREE_RESET  = 8'd3;
  localparam logic [MS_W-1:0]   BASE_RESET  = 32'd1000;
  localparam logic [MS_W-1:0]   MAX_RESET   = 32'd300000;
  localparam logic [MS_W-1:0]   DECAY_RESET = 32'd0;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_FAILURE = 2'd1,
    OP_SUCCESS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_FREE_ATTEMPTS = 2'd0,
    REG_BASE_LOCKOUT  = 2'd1,
    REG_MAX_LOCKOUT   = 2'd2,
    REG_DECAY_AFTER   = 2'd3
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== hw/rtl/failed_attempt_lockout_gate.sv =====
// ============================================================================
// failed_attempt_lockout_gate: lockout gate with exponential backoff
// Takes timestamped query, failure and success events, keeps the failure
// streak and answers each event with an ok/busy status and a retry time.
// ============================================================================
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata: now_ns; tuser: opcode
//  m_axis    out        tdata: retry_after_ms; tuser: gate_status
//  apb       in/out     four 32-bit registers at byte addresses 0, 4, 8, 12
//
//  One word is accepted every cycle while the result stream does not stall;
//  each result passes through the eight stages that end in the millisecond
//  divider and then the output register.
//  The streak state is updated as an event leaves the input register, so the
//  next event in the following cycle already sees it.
//  Reset clears the streak and loads the register defaults; no clearing pass.
//  A stalled result holds in the output register while empty stages fill.
//
`default_nettype none

module failed_attempt_lockout_gate (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Event stream in.
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [falg_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [63:0] now_ns
  input  wire logic [falg_pkg::IN_USER_W-1:0]   s_axis_tuser,  // [1:0] opcode
  // Result stream out.
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [falg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [32:0] retry_after_ms
  output      logic [falg_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // [0] gate_status
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [falg_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [falg_pkg::APB_DATA_W-1:0]  pwdata,
  output      logic [falg_pkg::APB_DATA_W-1:0]  prdata,
  output      logic                             pready
);

  import falg_pkg::*;

  localparam int unsigned NSTAGE = 8;

  // Configuration registers; the decay threshold is kept in nanoseconds too.
  logic [FREE_W-1:0] free_q;
  logic [MS_W-1:0]   base_q;
  logic [MS_W-1:0]   max_q;
  logic [MS_W-1:0]   decay_q;
  logic [NS_W-1:0]   decay_ns_q;
  reg_idx_e          reg_idx;

  // Streak state.
  logic [COUNT_W-1:0] count_q, count_d;
  logic [NOW_W-1:0]   last_q, last_d;
  logic               ever_q, ever_d;

  // Pipeline control.
  logic [NSTAGE:1]   vld_q;
  logic              out_vld_q;
  logic [NSTAGE+1:1] adv;

  // Stage payloads.
  op_e                s1_op_q;
  logic [NOW_W-1:0]   s1_now_q;
  logic               s2_live_q, s2_big_q;
  logic [NS_W-1:0]    s2_since_q;
  logic [COUNT_W-1:0] s2_count_q;
  logic               s3_live_q, s3_big_q;
  logic [NS_W-1:0]    s3_since_q;
  logic [MS_W-1:0]    s3_lock_q;
  logic               s4_live_q, s4_big_q;
  logic [NS_W-1:0]    s4_since_q;
  logic [NS_W-1:0]    s4_lock_ns_q;
  logic               s5_busy_q;
  logic [DIV_X_W-1:0] s5_x_q;
  logic               s6_busy_q;
  logic [PP_W-1:0]    s6_ll_q, s6_lh_q, s6_hl_q, s6_hh_q;
  logic               s7_busy_q;
  logic [PP_W-1:0]    s7_ll_q, s7_hh_q;
  logic [MID_W-1:0]   s7_mid_q;
  logic               s8_busy_q;
  logic [RETRY_W-1:0] s8_quot_q;
  logic               out_status_q;
  logic [RETRY_W-1:0] out_retry_q;

  // Stage logic.
  logic [NOW_W-1:0]   since_full;
  logic               decay_hit;
  logic               s1_live;
  logic [COUNT_W-1:0] cnt_base;
  logic [COUNT_W-1:0] over, shamt;
  logic [2*MS_W-1:0]  shifted;
  logic [MS_W-1:0]    lock;
  logic [NS_W-1:0]    lock_ns;
  logic               busy;
  logic [NS_W-1:0]    diff;
  logic [TOT_W-1:0]   total;
  logic [RETRY_W-1:0] quot;

  // --------------------------------------------------------------------------
  // Configuration port: writes in the access phase, reads are combinational.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q     <= FREE_RESET;
      base_q     <= BASE_RESET;
      max_q      <= MAX_RESET;
      decay_q    <= DECAY_RESET;
      decay_ns_q <= NS_W'(DECAY_RESET) * NS_W'(NS_PER_MS);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_FREE_ATTEMPTS: free_q <= pwdata[FREE_W-1:0];
        REG_BASE_LOCKOUT:  base_q <= pwdata[MS_W-1:0];
        REG_MAX_LOCKOUT:   max_q  <= pwdata[MS_W-1:0];
        REG_DECAY_AFTER: begin
          decay_q    <= pwdata[MS_W-1:0];
          decay_ns_q <= NS_W'(pwdata[MS_W-1:0]) * NS_W'(NS_PER_MS);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FREE_ATTEMPTS: prdata = APB_DATA_W'(free_q);
      REG_BASE_LOCKOUT:  prdata = APB_DATA_W'(base_q);
      REG_MAX_LOCKOUT:   prdata = APB_DATA_W'(max_q);
      REG_DECAY_AFTER:   prdata = APB_DATA_W'(decay_q);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: a stage moves on when it is empty or its successor does.
  // --------------------------------------------------------------------------
  always_comb begin
    adv[NSTAGE+1] = !out_vld_q || m_axis_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (adv[NSTAGE+1]) begin
        out_vld_q <= vld_q[NSTAGE];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: elapsed time, decay check and the streak update.
  // --------------------------------------------------------------------------
  always_comb begin
    since_full = (s1_now_q >= last_q) ? (s1_now_q - last_q) : '0;
    decay_hit  = (decay_q != '0) && (since_full >= NOW_W'(decay_ns_q));
    s1_live    = (s1_op_q == OP_QUERY) && ever_q && (count_q != '0) && !decay_hit;
  end

  always_comb begin
    count_d  = count_q;
    last_d   = last_q;
    ever_d   = ever_q;
    cnt_base = count_q;
    case (s1_op_q)
      OP_FAILURE: begin
        cnt_base = (ever_q && decay_hit) ? '0 : count_q;
        count_d  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + COUNT_W'(1);
        last_d   = s1_now_q;
        ever_d   = 1'b1;
      end
      OP_SUCCESS: begin
        count_d = '0;
        ever_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= '0;
      ever_q  <= 1'b0;
    end else if (vld_q[1] && adv[2]) begin
      count_q <= count_d;
      last_q  <= last_d;
      ever_q  <= ever_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: lockout in milliseconds from the failure count.
  // --------------------------------------------------------------------------
  always_comb begin
    over    = s2_count_q - COUNT_W'(free_q);
    shamt   = over - COUNT_W'(1);
    shifted = (2*MS_W)'(base_q) << shamt[5:0];
    if (s2_count_q <= COUNT_W'(free_q) || base_q == '0) begin
      lock = '0;
    end else if (shamt >= SHIFT_LIMIT) begin
      lock = max_q;
    end else if (shifted > (2*MS_W)'(max_q)) begin
      lock = max_q;
    end else begin
      lock = shifted[MS_W-1:0];
    end
  end

  // Stage 3: lockout in nanoseconds.
  assign lock_ns = NS_W'(s3_lock_q) * NS_W'(NS_PER_MS);

  // Stage 4: busy decision and the time still to wait.
  always_comb begin
    busy = s4_live_q && !s4_big_q && (s4_since_q < s4_lock_ns_q);
    diff = s4_lock_ns_q - s4_since_q;
  end

  // Stage 7: sum of partial products gives the whole milliseconds.
  always_comb begin
    total = TOT_W'(s7_ll_q) + (TOT_W'(s7_mid_q) << SPLIT) + (TOT_W'(s7_hh_q) << (2*SPLIT));
    quot  = total[TOT_W-1:RECIP_K];
  end

  // --------------------------------------------------------------------------
  // Stage registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_op_q  <= op_e'(s_axis_tuser);
      s1_now_q <= s_axis_tdata;
    end
    if (adv[2]) begin
      s2_live_q  <= s1_live;
      s2_big_q   <= |since_full[NOW_W-1:NS_W];
      s2_since_q <= since_full[NS_W-1:0];
      s2_count_q <= count_q;
    end
    if (adv[3]) begin
      s3_live_q  <= s2_live_q;
      s3_big_q   <= s2_big_q;
      s3_since_q <= s2_since_q;
      s3_lock_q  <= lock;
    end
    if (adv[4]) begin
      s4_live_q    <= s3_live_q && (s3_lock_q != '0);
      s4_big_q     <= s3_big_q;
      s4_since_q   <= s3_since_q;
      s4_lock_ns_q <= lock_ns;
    end
    if (adv[5]) begin
      s5_busy_q <= busy;
      s5_x_q    <= diff[NS_W-1:DIV_SHIFT];
    end
    // Stage 5 computes the four partial products of the reciprocal multiply.
    if (adv[6]) begin
      s6_busy_q <= s5_busy_q;
      s6_ll_q   <= PP_W'(s5_x_q[SPLIT-1:0]) * PP_W'(RECIP_M[SPLIT-1:0]);
      s6_lh_q   <= PP_W'(s5_x_q[SPLIT-1:0]) * PP_W'(RECIP_M[RECIP_W-1:SPLIT]);
      s6_hl_q   <= PP_W'(s5_x_q[DIV_X_W-1:SPLIT]) * PP_W'(RECIP_M[SPLIT-1:0]);
      s6_hh_q   <= PP_W'(s5_x_q[DIV_X_W-1:SPLIT]) * PP_W'(RECIP_M[RECIP_W-1:SPLIT]);
    end
    // Stage 6 folds the two middle products together.
    if (adv[7]) begin
      s7_busy_q <= s6_busy_q;
      s7_ll_q   <= s6_ll_q;
      s7_hh_q   <= s6_hh_q;
      s7_mid_q  <= MID_W'(s6_lh_q) + MID_W'(s6_hl_q);
    end
    if (adv[8]) begin
      s8_busy_q <= s7_busy_q;
      s8_quot_q <= quot;
    end
    // Output register: retry is the whole milliseconds left plus one.
    if (adv[NSTAGE+1]) begin
      out_status_q <= s8_busy_q;
      out_retry_q  <= s8_busy_q ? (s8_quot_q + RETRY_W'(1)) : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_retry_q);
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_failed_attempt_lockout_gate.sv =====
// ============================================================================
// tb_failed_attempt_lockout_gate: self-checking bench for the lockout gate
// Drives timestamped query, failure and success words into the event stream,
// predicts every answer from a model of the streak state and the registers
// kept here, and compares each result word field by field. A short directed
// part covers the extremes and the special cases; random failure streaks
// aimed at the lockout and decay boundaries follow under several register
// settings, with random gaps and stalls on both streams.
// ============================================================================
`timescale 1ns / 1ps

module tb_failed_attempt_lockout_gate;
  import falg_pkg::*;

  localparam logic [63:0] NS_IN_MS     = 64'd1_000_000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned PHASE_EVENTS = 180;
  localparam int unsigned PHASE_COUNT  = 8;

  typedef struct packed {
    logic        status;
    logic [32:0] retry;
  } gate_answer_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Event stream, result stream and configuration port.
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [63:0] now_ns
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // [1:0] opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [32:0] retry_after_ms
  logic [OUT_USER_W-1:0] m_axis_tuser;        // [0] gate_status
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Register copies and streak state of the gate model.
  logic [FREE_W-1:0]  cfg_free  = FREE_RESET;
  logic [MS_W-1:0]    cfg_base  = BASE_RESET;
  logic [MS_W-1:0]    cfg_max   = MAX_RESET;
  logic [MS_W-1:0]    cfg_decay = DECAY_RESET;
  logic [COUNT_W-1:0] streak_count = '0;
  logic [NOW_W-1:0]   last_fail_ns = '0;
  logic               ever_failed  = 1'b0;

  gate_answer_t pending_answers[$];
  int unsigned  fault_count  = 0;
  int unsigned  events_sent  = 0;
  logic         quiet_stretch = 1'b0;
  logic [63:0]  clock_ns = '0;

  failed_attempt_lockout_gate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycles that one side idles before its next word.
  function automatic int unsigned pace_draw();
    return quiet_stretch ? 0 : $urandom_range(0, 9);
  endfunction

  // True once the quiet time since the last failure has reached the decay time.
  function automatic logic has_decayed(logic [63:0] since);
    return cfg_decay != '0 && since >= {32'd0, cfg_decay} * NS_IN_MS;
  endfunction

  // Lockout in milliseconds for a given streak: doubling past the free
  // attempts, capped at the maximum.
  function automatic logic [63:0] lockout_for(logic [COUNT_W-1:0] count);
    logic [31:0] over;
    logic [63:0] shifted;
    if (count <= {24'd0, cfg_free}) return 64'd0;
    if (cfg_base == '0) return 64'd0;
    over = count - {24'd0, cfg_free};
    if (over - 32'd1 >= 32'd33) return {32'd0, cfg_max};
    shifted = {32'd0, cfg_base} << (over - 32'd1);
    return (shifted > {32'd0, cfg_max}) ? {32'd0, cfg_max} : shifted;
  endfunction

  // Works out the answer to one accepted event and moves the streak state on.
  task automatic apply_event(input logic [1:0] op, input logic [63:0] now,
                             output gate_answer_t answer);
    logic [63:0] since;
    logic [63:0] lock_ms;
    logic [63:0] lock_ns;
    since = (now >= last_fail_ns) ? now - last_fail_ns : 64'd0;
    answer = '0;
    case (op)
      OP_QUERY: begin
        if (ever_failed && streak_count != '0 && !has_decayed(since)) begin
          lock_ms = lockout_for(streak_count);
          lock_ns = lock_ms * NS_IN_MS;
          if (lock_ms != 64'd0 && since < lock_ns) begin
            answer.status = 1'b1;
            answer.retry  = 33'((lock_ns - since) / NS_IN_MS + 64'd1);
          end
        end
      end
      OP_FAILURE: begin
        if (ever_failed && has_decayed(since)) streak_count = '0;
        if (streak_count != COUNT_MAX) streak_count = streak_count + 1'b1;
        last_fail_ns = now;
        ever_failed  = 1'b1;
      end
      OP_SUCCESS: begin
        streak_count = '0;
        ever_failed  = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Sends one event word and records the answer it must produce.
  task automatic send_event(input logic [1:0] op, input logic [63:0] now);
    int unsigned  gap;
    gate_answer_t answer;
    gap = pace_draw();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    apply_event(op, now, answer);
    pending_answers.push_back(answer);
    events_sent++;
  endtask

  // Holds the event stream idle until every outstanding answer has arrived.
  task automatic wait_for_answers();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // Writes one register, then reads it back.
  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] read_want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // The write has landed; turn the same address round into a read.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FREE_ATTEMPTS: cfg_free  = value[FREE_W-1:0];
      REG_BASE_LOCKOUT:  cfg_base  = value;
      REG_MAX_LOCKOUT:   cfg_max   = value;
      default:           cfg_decay = value;
    endcase
    read_want = (idx == REG_FREE_ATTEMPTS) ? {24'd0, value[FREE_W-1:0]} : value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== read_want) begin
      $error("register %s: expected %0h, got %0h", idx.name(), read_want, prdata);
      fault_count++;
    end
  endtask

  // Quiet time between events: from nothing up to several minutes.
  function automatic logic [63:0] idle_ns();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return 64'($urandom_range(1, 999));
      2:       return 64'($urandom_range(0, 10000)) * 64'd1000;
      3:       return 64'($urandom_range(0, 5000)) * NS_IN_MS;
      default: return 64'($urandom_range(0, 400)) * NS_IN_MS * 64'd1000;
    endcase
  endfunction

  // Time of the next failure, sometimes right at the decay edge.
  function automatic logic [63:0] failure_time();
    if (cfg_decay != '0 && $urandom_range(0, 5) == 0)
      clock_ns = last_fail_ns + {32'd0, cfg_decay} * NS_IN_MS
                 + 64'($urandom_range(0, 2)) - 64'd1;
    else
      clock_ns = clock_ns + idle_ns();
    return clock_ns;
  endfunction

  // Time of a query, often aimed one nanosecond around the end of the
  // lockout or the decay time.
  function automatic logic [63:0] query_time();
    logic [63:0] lock_ns;
    lock_ns = lockout_for(streak_count) * NS_IN_MS;
    case ($urandom_range(0, 4))
      0: clock_ns = last_fail_ns + lock_ns + 64'($urandom_range(0, 2)) - 64'd1;
      1: clock_ns = last_fail_ns + {32'd0, cfg_decay} * NS_IN_MS
                    + 64'($urandom_range(0, 2)) - 64'd1;
      2: clock_ns = last_fail_ns + (lock_ns >> $urandom_range(1, 8));
      default: clock_ns = clock_ns + idle_ns();
    endcase
    return clock_ns;
  endfunction

  // One failure streak: failures, aimed queries and noise words until the streak
  // reaches a target at or past the free attempts, more queries, then usually a success.
  task automatic run_session();
    int unsigned target;
    int unsigned tries;
    int unsigned pick;
    target = cfg_free + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 6));
    quiet_stretch = ($urandom_range(0, 3) == 0);
    tries = 0;
    while (streak_count < target && tries < 3 * target + 10) begin
      // Long streaks get mostly failures so that they end in a lockout.
      pick = $urandom_range(0, (target > 40) ? 65 : 99);
      tries++;
      if (pick < 55)
        send_event(OP_FAILURE, failure_time());
      else if (pick < 85)
        send_event(OP_QUERY, query_time());
      else if (pick < 90)
        send_event(OP_UNUSED, {$urandom, $urandom});
      else if (pick < 95)
        send_event(2'($urandom_range(0, 3)), {$urandom, $urandom});
      else
        send_event(OP_QUERY, last_fail_ns - 64'($urandom_range(1, 1000000000)));
    end
    repeat ($urandom_range(1, 4)) send_event(OP_QUERY, query_time());
    if ($urandom_range(0, 3) != 0) send_event(OP_SUCCESS, clock_ns + idle_ns());
  endtask

  // A gate that has never failed answers ok.
  task automatic test_fresh_gate();
    send_event(OP_QUERY, 64'd0);
    send_event(OP_SUCCESS, 64'd5);
  endtask

  // Default registers: lockout after the fourth failure, its end to the
  // nanosecond, time running backwards, the unused opcode and a success.
  task automatic test_default_backoff();
    logic [63:0] t0;
    t0 = NS_IN_MS;
    for (int i = 0; i < 4; i++) send_event(OP_FAILURE, t0 + 64'(i));
    send_event(OP_QUERY, t0 + 64'd3);
    send_event(OP_QUERY, t0 + 64'd3 + 64'd1_000_000_000 - 64'd1);
    send_event(OP_QUERY, t0 + 64'd3 + 64'd1_000_000_000);
    send_event(OP_QUERY, 64'd0);
    send_event(OP_UNUSED, t0 + 64'd5);
    send_event(OP_FAILURE, t0 + 64'd10);
    send_event(OP_QUERY, t0 + 64'd10 + 64'd500_000_000);
    send_event(OP_SUCCESS, t0 + 64'd20);
    send_event(OP_QUERY, t0 + 64'd21);
  endtask

  // Registers at their extremes: the largest retry time, a base above the
  // cap, and a zero base that never locks.
  task automatic test_register_extremes();
    wait_for_answers();
    write_register(REG_FREE_ATTEMPTS, 32'd0);
    write_register(REG_BASE_LOCKOUT, 32'hFFFF_FFFF);
    write_register(REG_MAX_LOCKOUT, 32'hFFFF_FFFF);
    write_register(REG_DECAY_AFTER, 32'hFFFF_FFFF);
    send_event(OP_FAILURE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(OP_QUERY, 64'd0);
    send_event(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_for_answers();
    write_register(REG_BASE_LOCKOUT, 32'd5000);
    write_register(REG_MAX_LOCKOUT, 32'd10);
    send_event(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_for_answers();
    write_register(REG_BASE_LOCKOUT, 32'd0);
    send_event(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(OP_SUCCESS, 64'd0);
  endtask

  // Decay of one millisecond: the streak is forgotten exactly at the edge,
  // both for a query and for the next failure.
  task automatic test_decay();
    logic [63:0] t0;
    t0 = 64'd1_000_000_000;
    wait_for_answers();
    write_register(REG_FREE_ATTEMPTS, 32'd0);
    write_register(REG_BASE_LOCKOUT, 32'd1000);
    write_register(REG_MAX_LOCKOUT, 32'd300000);
    write_register(REG_DECAY_AFTER, 32'd1);
    send_event(OP_FAILURE, t0);
    send_event(OP_QUERY, t0 + NS_IN_MS - 64'd1);
    send_event(OP_QUERY, t0 + NS_IN_MS);
    send_event(OP_FAILURE, t0 + NS_IN_MS);
    send_event(OP_QUERY, t0 + NS_IN_MS);
    wait_for_answers();
    write_register(REG_FREE_ATTEMPTS, 32'd255);
    send_event(OP_QUERY, t0 + NS_IN_MS);
  endtask

  // Random streaks under a different register setting in each phase; the
  // event stream drains fully before every change of setting.
  task automatic test_random_sessions();
    logic [31:0] free_v;
    logic [31:0] base_v;
    logic [31:0] max_v;
    logic [31:0] decay_v;
    int unsigned phase_start;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          free_v = 32'd3; base_v = 32'd1000; max_v = 32'd300000;
          decay_v = $urandom_range(1, 5000);
        end
        1: begin
          free_v = 32'd0; base_v = 32'd1; max_v = 32'hFFFF_FFFF; decay_v = 32'd0;
        end
        2: begin
          free_v = 32'd255; base_v = $urandom_range(1, 4000); max_v = $urandom;
          decay_v = 32'd0;
        end
        3: begin
          free_v = $urandom_range(0, 4); base_v = 32'hFFFF_FFFF; max_v = $urandom;
          decay_v = $urandom_range(0, 100000);
        end
        4: begin
          free_v = $urandom_range(0, 6); base_v = 32'd0; max_v = $urandom;
          decay_v = $urandom_range(0, 100);
        end
        5: begin
          free_v = $urandom; base_v = $urandom; max_v = $urandom; decay_v = $urandom;
        end
        6: begin
          free_v = $urandom_range(0, 3); base_v = $urandom_range(1, 100);
          max_v = $urandom_range(0, 1000); decay_v = $urandom_range(1, 50);
        end
        default: begin
          free_v = $urandom_range(0, 8); base_v = $urandom_range(1, 2000);
          max_v = $urandom_range(1000, 1000000); decay_v = $urandom_range(0, 2000);
        end
      endcase
      wait_for_answers();
      write_register(REG_FREE_ATTEMPTS, free_v);
      write_register(REG_BASE_LOCKOUT, base_v);
      write_register(REG_MAX_LOCKOUT, max_v);
      write_register(REG_DECAY_AFTER, decay_v);
      clock_ns = {$urandom_range(0, 4095), $urandom};
      phase_start = events_sent;
      while (events_sent - phase_start < PHASE_EVENTS) run_session();
    end
  endtask

  // Result side: random stalls, then each result word against the oldest
  // expected answer.
  initial begin : result_checker
    int unsigned  stall;
    gate_answer_t want;
    @(posedge rst_ni);
    forever begin
      stall = pace_draw();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      if (pending_answers.size() == 0) begin
        $error("result word with no event waiting for it");
        fault_count++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tuser[0] !== want.status) begin
          $error("gate_status: expected %0d, got %0d", want.status, m_axis_tuser[0]);
          fault_count++;
        end
        if (m_axis_tdata[RETRY_W-1:0] !== want.retry) begin
          $error("retry_after_ms: expected %0d, got %0d", want.retry,
                 m_axis_tdata[RETRY_W-1:0]);
          fault_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin : test_sequence
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fresh_gate();
    test_default_backoff();
    test_register_extremes();
    test_decay();
    test_random_sessions();
    wait_for_answers();
    // Room for any stray word to leave the pipeline.
    repeat (30) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a stream that hangs.
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
